// File: hw/rtl/eopp_pkg.sv
// ----------------------------------------------------------------------------
// eopp_pkg: shared types and constants of the escape orbit pixel plotter
// Controller states, the register map, the mapper result and fixed-point
// constants.
// ----------------------------------------------------------------------------
package eopp_pkg;

  localparam int unsigned FRAC = 28;

  // floor(6.05 * 2^56)
  localparam logic [63:0] ESC_LIMIT = (64'd121 << 54) / 64'd5;

  localparam logic [12:0] DIM_MAX = 13'd4096;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADV,
    ST_RD,
    ST_MAP1,
    ST_MAP2,
    ST_EMIT,
    ST_SUM
  } state_e;

  typedef struct packed {
    logic        hit;
    logic [11:0] col;
    logic [11:0] row;
  } map_res_t;

endpackage

// File: hw/rtl/escape_orbit_pixel_plotter_top.sv
// ----------------------------------------------------------------------------
// escape_orbit_pixel_plotter_top: orbit plotter for one complex point
// Iterates z = z*z + c, keeps the orbit in a memory and replays it as
// pixel hits once the point escapes, then closes with a summary beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one point c per beat,
//   signed Q3.28. The output channel (out_valid_o / out_ready_i) returns
//   zero or more hit beats (last_of_run_o = 0) followed by exactly one
//   summary beat (last_of_run_o = 1) per point.
//   Each orbit step runs through ST_MUL, where the three 33x33
//   multipliers form the products, and ST_ADV, which adds c, tests
//   |z|^2 and writes the new point into the orbit memory. The test of
//   step n rides on the products of the next round. Replay takes each
//   stored point through a memory read, two mapper stages and the
//   output load, plus any wait on the receiver. One point is worked on
//   at a time; the next is taken while the summary of the previous one
//   still waits in the output register.
//   Reset clears the running totals and sets both image sizes to 1024.
//   A stalled receiver holds the output register and freezes the replay.
//   Write the image sizes only while idle.
// ----------------------------------------------------------------------------
module escape_orbit_pixel_plotter_top #(
  parameter int unsigned NMAX = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [12:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [30:0] c_real_i,
  input  logic signed [30:0] c_imag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               last_of_run_o,
  output logic [11:0]        pixel_column_o,
  output logic [11:0]        pixel_row_o,
  output logic [5:0]         orbit_index_o,
  output logic               escaped_o,
  output logic [6:0]         iteration_count_o,
  output logic [31:0]        discarded_total_o,
  output logic [39:0]        escape_step_total_o
);
  import eopp_pkg::*;

  localparam int unsigned AW   = $clog2(NMAX);
  localparam int unsigned CNTW = $clog2(NMAX + 1);
  localparam logic [CNTW-1:0] CntMax = CNTW'(NMAX);

  state_e state_q, state_d;

  logic [12:0] width_q, height_q, eff_w, eff_h;
  logic signed [30:0] cr_q, ci_q;
  logic signed [32:0] x_q, y_q, xn, yn;
  logic signed [65:0] pxx_q, pyy_q, pxy_q, diff;
  logic [66:0] mag2;
  logic        escape;
  logic [CNTW-1:0] cnt_q, n_q, j_q;
  logic        esc_q;
  logic [31:0] disc_q;
  logic [39:0] esum_q;
  logic [40:0] esum_add;

  logic [65:0] orbit_mem [NMAX];
  logic [65:0] rdata_q;
  map_res_t    map_res;

  logic out_free, load_hit, load_sum;

  // Output register
  logic        out_valid_q, last_q, esc_out_q;
  logic [11:0] col_q, row_q;
  logic [5:0]  idx_q;
  logic [6:0]  icnt_q;
  logic [31:0] disc_out_q;
  logic [39:0] esum_out_q;

  // Configuration: clamp oversized sizes to 4096
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1024;
      height_q <= 13'd1024;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
    end
  end

  assign eff_w = (width_q  > DIM_MAX) ? DIM_MAX : width_q;
  assign eff_h = (height_q > DIM_MAX) ? DIM_MAX : height_q;

  // Iteration datapath: products of the latest z, then advance
  always_comb begin
    diff     = pxx_q - pyy_q;
    xn       = 33'(diff >>> FRAC) + 33'(cr_q);
    yn       = 33'(pxy_q >>> (FRAC - 1)) + 33'(ci_q);
    mag2     = 67'($unsigned(pxx_q)) + 67'($unsigned(pyy_q));
    escape   = mag2 > 67'(ESC_LIMIT);
    esum_add = {1'b0, esum_q} + 41'(cnt_q - CNTW'(1));
  end

  always_ff @(posedge clk_i) begin
    pxx_q <= 66'(x_q) * 66'(x_q);
    pyy_q <= 66'(y_q) * 66'(y_q);
    pxy_q <= 66'(x_q) * 66'(y_q);
  end

  // Orbit memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ADV && !escape && cnt_q != CntMax) begin
      orbit_mem[cnt_q[AW-1:0]] <= {yn, xn};
    end
    rdata_q <= orbit_mem[j_q[AW-1:0]];
  end

  eopp_pixel_map u_map (
    .clk_i    (clk_i),
    .re_i     ($signed(rdata_q[32:0])),
    .im_i     ($signed(rdata_q[65:33])),
    .width_i  (eff_w),
    .height_i (eff_h),
    .res_o    (map_res)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // Controller
  always_comb begin
    state_d  = state_q;
    load_hit = 1'b0;
    load_sum = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_ADV;
      ST_ADV: begin
        if (escape) begin
          state_d = (cnt_q == CNTW'(1)) ? ST_SUM : ST_RD;
        end else if (cnt_q == CntMax) begin
          state_d = ST_SUM;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_RD:   state_d = ST_MAP1;
      ST_MAP1: state_d = ST_MAP2;
      ST_MAP2: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!map_res.hit || out_free) begin
          load_hit = map_res.hit;
          state_d  = (j_q + CNTW'(1) == n_q) ? ST_SUM : ST_RD;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          load_sum = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Orbit control and running totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      n_q    <= '0;
      j_q    <= '0;
      esc_q  <= 1'b0;
      disc_q <= '0;
      esum_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
        end
        ST_ADV: begin
          j_q <= '0;
          if (escape) begin
            // the point in x/y is the first outside the limit
            esc_q  <= 1'b1;
            n_q    <= cnt_q - CNTW'(1);
            esum_q <= esum_add[40] ? '1 : esum_add[39:0];
          end else if (cnt_q == CntMax) begin
            esc_q <= 1'b0;
            n_q   <= CntMax;
            if (disc_q != '1) disc_q <= disc_q + 32'd1;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        ST_EMIT: begin
          if (!map_res.hit || out_free) j_q <= j_q + CNTW'(1);
        end
        default: ;
      endcase
    end
  end

  // Point registers, loaded at accept and on each step
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      cr_q <= c_real_i;
      ci_q <= c_imag_i;
      x_q  <= '0;
      y_q  <= '0;
    end else if (state_q == ST_ADV) begin
      x_q <= xn;
      y_q <= yn;
    end
  end

  // Output register: hold while stalled, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_hit || load_sum) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      last_q     <= 1'b0;
      col_q      <= map_res.col;
      row_q      <= map_res.row;
      idx_q      <= 6'(j_q);
      esc_out_q  <= 1'b0;
      icnt_q     <= '0;
      disc_out_q <= '0;
      esum_out_q <= '0;
    end else if (load_sum) begin
      last_q     <= 1'b1;
      col_q      <= '0;
      row_q      <= '0;
      idx_q      <= '0;
      esc_out_q  <= esc_q;
      icnt_q     <= 7'(n_q);
      disc_out_q <= disc_q;
      esum_out_q <= esum_q;
    end
  end

  assign in_ready_o          = (state_q == ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign last_of_run_o       = last_q;
  assign pixel_column_o      = col_q;
  assign pixel_row_o         = row_q;
  assign orbit_index_o       = idx_q;
  assign escaped_o           = esc_out_q;
  assign iteration_count_o   = icnt_q;
  assign discarded_total_o   = disc_out_q;
  assign escape_step_total_o = esum_out_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("orbit count beyond NMAX");

  a_replay_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> (j_q < n_q))
    else $error("replay index beyond escape step");

  a_discard_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o && !escaped_o) |-> (iteration_count_o == 7'(NMAX)))
    else $error("discarded point without full count");

  a_hit_on_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |->
      (13'(pixel_column_o) < eff_w && 13'(pixel_row_o) < eff_h))
    else $error("hit outside the image");

endmodule

// File: hw/rtl/eopp_pixel_map.sv
// ----------------------------------------------------------------------------
// eopp_pixel_map: orbit point to pixel mapping
// Two register stages: scale by the image size, then divide by the
// constant denominators and check the image bounds.
// ----------------------------------------------------------------------------
module eopp_pixel_map (
  input  logic                  clk_i,
  input  logic signed [32:0]    re_i,
  input  logic signed [32:0]    im_i,
  input  logic [12:0]           width_i,
  input  logic [12:0]           height_i,
  output eopp_pkg::map_res_t    res_o
);
  import eopp_pkg::*;

  // 21 * 2^28 and 3 * 2^28
  localparam logic signed [37:0] RowOfs = 38'sd5637144576;
  localparam logic signed [37:0] ColOfs = 38'sd805306368;
  // ceil(2^22 / 15) and ceil(2^18 / 3)
  localparam logic [18:0] RecipRow = 19'd279621;
  localparam logic [16:0] RecipCol = 17'd87382;

  logic signed [37:0] nrow, ncol;
  logic signed [51:0] prow_d, pcol_d;
  logic signed [51:0] prow_q, pcol_q;
  logic [51:0]        arow, acol;
  logic [21:0]        vrow;
  logic [22:0]        vcol;
  logic [40:0]        mrow;
  logic [39:0]        mcol;
  logic [18:0]        qrow;
  logic [21:0]        qcol;
  logic               row_ok, col_ok;
  map_res_t           res_d, res_q;

  // Stage 1: scaled numerators
  always_comb begin
    nrow   = RowOfs - 38'(re_i) * 38'sd20;
    ncol   = ColOfs + (38'(im_i) <<< 1);
    prow_d = 52'(nrow) * 52'($signed({1'b0, height_i}));
    pcol_d = 52'(ncol) * 52'($signed({1'b0, width_i}));
  end

  always_ff @(posedge clk_i) begin
    prow_q <= prow_d;
    pcol_q <= pcol_d;
  end

  // Stage 2: truncating divide on the magnitude, then bounds check
  always_comb begin
    arow   = prow_q[51] ? 52'(-prow_q) : 52'(prow_q);
    acol   = pcol_q[51] ? 52'(-pcol_q) : 52'(pcol_q);
    vrow   = arow[51:30];
    vcol   = acol[51:29];
    mrow   = 41'(vrow) * 41'(RecipRow);
    mcol   = 40'(vcol) * 40'(RecipCol);
    qrow   = mrow[40:22];
    qcol   = mcol[39:18];
    row_ok = (!prow_q[51] || (qrow == 19'd0)) && (qrow < 19'(height_i));
    col_ok = (!pcol_q[51] || (qcol == 22'd0)) && (qcol < 22'(width_i));
    res_d.hit = row_ok && col_ok;
    res_d.row = qrow[11:0];
    res_d.col = qcol[11:0];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule
